// ===== src/jacobi_linear_solver_macros.svh =====
// Assertion macros for the Jacobi solver.
// Depends on nothing; included by the top level.
`ifndef JACOBI_LINEAR_SOLVER_MACROS_SVH
`define JACOBI_LINEAR_SOLVER_MACROS_SVH
`define JLS_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define JLS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

// ===== src/jls_pkg.sv =====
// Package for the Jacobi solver: widths, codes, command and status types.
// Depends on nothing.
`default_nettype none
package jls_pkg;
    localparam int MaxUnknownsDefault = 32;
    localparam int DataW = 32;
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0, CMD_LOAD_B = 2'd1, CMD_START = 2'd2, CMD_NONE = 2'd3
    } cmd_t;
    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0, ST_LIMIT = 2'd1, ST_ZERO_DIAG = 2'd2, ST_UNUSED = 2'd3
    } status_t;
    typedef enum logic [1:0] {
        REG_SIZE = 2'd0, REG_TOL = 2'd1, REG_LIMIT = 2'd2, REG_NONE = 2'd3
    } reg_idx_t;
endpackage
`default_nettype wire

// ===== src/jls_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none
module jls_ram #(
    parameter int Width = 32,
    parameter int Depth = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/jls_div.sv =====
// Restoring divider, one quotient bit a cycle: (num * 65536) / den, truncated.
// Depends on jls_pkg.
`default_nettype none
module jls_div
    import jls_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [47:0] num,
    input  wire logic signed [31:0] den,
    output logic                    busy,
    output logic                    done,
    output logic signed [31:0]      quot
);
    localparam int NW = 64;
    logic [NW-1:0]  dvd_reg, dvd_next;
    logic [NW-1:0]  q_reg, q_next;
    logic [32:0]    rem_reg, rem_next;
    logic [31:0]    dv_reg, dv_next;
    logic           neg_reg, neg_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next, done_reg, done_next;
    logic [NW-1:0]  an;
    logic [33:0]    trial;
    logic signed [64:0] sq;

    always_comb begin
        an = num[47] ? NW'(-({{16{num[47]}}, num})) : NW'({16'd0, num});
        an = {an[47:0], 16'd0};
        trial = {1'b0, rem_reg} * 34'd2 + {33'd0, dvd_reg[NW-1]} - {2'd0, dv_reg};
        dvd_next = dvd_reg; q_next = q_reg; rem_next = rem_reg; dv_next = dv_reg;
        neg_next = neg_reg; cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (start) begin
            dvd_next = an; q_next = '0; rem_next = '0;
            dv_next = den[31] ? 32'(-den) : den;
            neg_next = num[47] ^ den[31];
            cnt_next = 7'd64; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[33]) begin
                rem_next = trial[32:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = 33'({rem_reg[31:0], dvd_reg[NW-1]});
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
        sq = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        if (sq > 65'sd2147483647) quot = 32'h7fffffff;
        else if (sq < -65'sd2147483648) quot = 32'h80000000;
        else quot = sq[31:0];
    end
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next; q_reg <= q_next; rem_reg <= rem_next;
        dv_reg <= dv_next; neg_reg <= neg_next;
        if (!aresetn) begin
            cnt_reg <= '0; busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next; busy_reg <= busy_next; done_reg <= done_next;
        end
    end
    assign busy = busy_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// ===== src/jacobi_linear_solver.sv =====
// Jacobi iterative solver, signed Q16.16, with a coefficient RAM, a rhs RAM
// and two estimate RAMs. A load item is written straight into its RAM. A
// start item holds the input side for the whole solve: a diagonal check,
// then sweeps, each of which does multiply-accumulate through the coefficient
// RAM port and a bit-serial division per unknown, then a tolerance check and,
// when another sweep follows, a copy. Results then leave one at a time, each
// only after the one before it has been taken.
// Depends on jls_pkg, jls_ram, jls_div and the macros header.
`default_nettype none
`include "jacobi_linear_solver_macros.svh"
module jacobi_linear_solver
    import jls_pkg::*;
#(
    parameter int MAX_UNKNOWNS = MaxUnknownsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0], row[6:2], column[11:7], entry_value[43:12], zero[47:44]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // unknown_index[4:0], solution_value[36:5], sweeps_done[53:37],
    // solve_status[55:54]
    output logic [55:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_wdata
);
    localparam int AW = $clog2(MAX_UNKNOWNS);
    localparam int CW = 2 * AW;
    localparam int Cap = (MAX_UNKNOWNS < 32) ? MAX_UNKNOWNS : 32;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001, S_DIAG = 9'b000000010, S_ACC = 9'b000000100,
        S_DIV   = 9'b000001000, S_DWAIT = 9'b000010000, S_CHK = 9'b000100000,
        S_COPY  = 9'b001000000, S_OUT = 9'b010000000, S_OWAIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0]  size_reg;
    logic [30:0] tol_reg;
    logic [15:0] lim_reg;

    logic [1:0]  in_cmd;
    logic [4:0]  in_row, in_col;
    logic [31:0] in_val;
    logic [AW-1:0] in_row_a, in_col_a;
    assign in_cmd = s_tdata[1:0];
    assign in_row = s_tdata[6:2];
    assign in_col = s_tdata[11:7];
    assign in_val = s_tdata[43:12];
    assign in_row_a = AW'(in_row);
    assign in_col_a = AW'(in_col);

    logic [AW:0] n;
    always_comb begin
        if (size_reg == 6'd0) n = (AW+1)'(1);
        else if (32'(size_reg) > Cap) n = (AW+1)'(Cap);
        else n = (AW+1)'(size_reg);
    end

    logic [AW:0]  i_reg, i_next, j_reg, j_next;
    logic [16:0]  sw_reg, sw_next;
    logic [1:0]   st_reg, st_next;
    logic         zero_reg, zero_next, conv_reg, conv_next, ld_reg, ld_next;
    logic signed [52:0] acc_reg, acc_next;
    logic signed [31:0] b_reg, b_next, d_reg, d_next;

    logic         a_we, b_we, p_we, c_we;
    logic [CW-1:0] a_wa, a_ra;
    logic [AW-1:0] b_wa, b_ra, p_wa, p_ra, c_wa, c_ra;
    logic [31:0]  a_wd, b_wd, p_wd, c_wd, a_rd, b_rd, p_rd, c_rd;

    jls_ram #(.Width(32), .Depth(1 << CW)) u_a (
        .aclk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
    jls_ram #(.Width(32), .Depth(MAX_UNKNOWNS)) u_b (
        .aclk, .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
    jls_ram #(.Width(32), .Depth(MAX_UNKNOWNS)) u_p (
        .aclk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    jls_ram #(.Width(32), .Depth(MAX_UNKNOWNS)) u_c (
        .aclk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

    // Previous estimate reads as zero in the first sweep.
    logic [31:0] xp;
    assign xp = (sw_reg == 17'd1) ? 32'd0 : p_rd;

    logic div_start, div_busy, div_done;
    logic signed [31:0] quot;
    logic signed [47:0] numer;
    logic signed [63:0] prod;
    logic signed [32:0] diff;
    logic [32:0] adiff;
    assign prod = $signed(a_rd) * $signed(xp);

    jls_div u_div (.aclk, .aresetn, .start(div_start), .num(numer), .den(d_reg),
        .busy(div_busy), .done(div_done), .quot(quot));

    always_comb begin
        logic signed [53:0] nm;
        logic signed [63:0] pt;
        nm = 54'(b_reg) - 54'(acc_reg);
        if (nm > 54'sd70368744177664) nm = 54'sd70368744177664;
        if (nm < -54'sd70368744177664) nm = -54'sd70368744177664;
        numer = nm[47:0];
        pt = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);
        state_next = state_reg; i_next = i_reg; j_next = j_reg; sw_next = sw_reg;
        st_next = st_reg; zero_next = zero_reg; conv_next = conv_reg; ld_next = 1'b0;
        acc_next = acc_reg; b_next = b_reg; d_next = d_reg;
        a_we = 1'b0; b_we = 1'b0; p_we = 1'b0; c_we = 1'b0;
        a_wa = {in_row_a, in_col_a};
        a_wd = in_val; b_wa = in_row_a; b_wd = in_val;
        a_ra = {i_reg[AW-1:0], j_reg[AW-1:0]}; b_ra = i_reg[AW-1:0];
        p_ra = j_reg[AW-1:0];
        p_wa = i_reg[AW-1:0]; p_wd = c_rd; c_wa = i_reg[AW-1:0]; c_wd = quot;
        div_start = 1'b0;
        diff = 33'($signed(c_rd)) - 33'($signed(xp));
        adiff = diff[32] ? 33'(-diff) : diff;
        s_tready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: if (s_tvalid) begin
                if (in_cmd == CMD_LOAD_A) begin
                    a_we = (32'(in_row) < MAX_UNKNOWNS) && (32'(in_col) < MAX_UNKNOWNS);
                end else if (in_cmd == CMD_LOAD_B) begin
                    b_we = 32'(in_row) < MAX_UNKNOWNS;
                end else if (in_cmd == CMD_START) begin
                    state_next = S_DIAG; i_next = '0; j_next = '0; sw_next = '0;
                    zero_next = 1'b0; ld_next = 1'b0;
                end
            end
            S_DIAG: begin
                a_ra = {i_reg[AW-1:0], i_reg[AW-1:0]};
                if (ld_reg && a_rd == 32'd0) zero_next = 1'b1;
                ld_next = 1'b1;
                if (ld_reg) begin
                    if (i_reg + 1'b1 == n) begin
                        if (zero_next) begin
                            st_next = ST_ZERO_DIAG; state_next = S_OUT; i_next = '0;
                        end else begin
                            state_next = S_ACC; i_next = '0; j_next = '0; ld_next = 1'b0;
                            sw_next = 17'd1; acc_next = '0;
                        end
                    end else begin
                        i_next = i_reg + 1'b1; ld_next = 1'b0;
                    end
                end
            end
            S_ACC: begin
                // Issue read of (i,j); the read issued the cycle before is accumulated, or kept as divisor if diagonal.
                ld_next = (j_reg < n);
                if (ld_reg) begin
                    if (j_reg - 1'b1 == i_reg) d_next = a_rd;
                    else acc_next = acc_reg + 53'(pt);
                end
                if (j_reg == (AW+1)'(1)) b_next = b_rd;
                if (j_reg < n) j_next = j_reg + 1'b1;
                else if (!ld_reg) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                div_start = 1'b1; state_next = S_DWAIT;
            end
            S_DWAIT: if (div_done) begin
                c_we = 1'b1; acc_next = '0; j_next = '0;
                if (i_reg + 1'b1 == n) begin
                    i_next = '0; state_next = S_CHK; conv_next = 1'b1; ld_next = 1'b0;
                end else begin
                    i_next = i_reg + 1'b1; state_next = S_ACC;
                end
            end
            S_CHK: begin
                p_ra = i_reg[AW-1:0];
                ld_next = 1'b1;
                if (ld_reg) begin
                    if (adiff > 33'(tol_reg)) conv_next = 1'b0;
                    if (i_reg + 1'b1 == n) begin
                        i_next = '0; ld_next = 1'b0;
                        if (sw_reg > 17'(lim_reg)) begin
                            st_next = ST_LIMIT; state_next = S_OUT;
                        end else if (conv_next) begin
                            st_next = ST_CONVERGED; state_next = S_OUT;
                        end else state_next = S_COPY;
                    end else begin
                        i_next = i_reg + 1'b1; ld_next = 1'b0;
                    end
                end
            end
            S_COPY: begin
                ld_next = 1'b1;
                if (ld_reg) begin
                    p_we = 1'b1; ld_next = 1'b0;
                    if (i_reg + 1'b1 == n) begin
                        i_next = '0; j_next = '0; sw_next = sw_reg + 17'd1;
                        state_next = S_ACC; acc_next = '0;
                    end else i_next = i_reg + 1'b1;
                end
            end
            S_OUT: state_next = S_OWAIT;
            S_OWAIT: if (m_tready) begin
                if (i_reg + 1'b1 == n) state_next = S_IDLE;
                else begin
                    i_next = i_reg + 1'b1; state_next = S_OUT;
                end
            end
            default: state_next = S_IDLE;
        endcase
        c_ra = i_next[AW-1:0];
    end

    logic m_valid_reg;
    logic [55:0] m_data_reg;
    logic m_last_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; size_reg <= 6'd4; tol_reg <= 31'd66; lim_reg <= 16'd10000;
            ld_reg <= 1'b0; i_reg <= '0; j_reg <= '0; sw_reg <= '0; st_reg <= ST_CONVERGED;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ld_reg <= ld_next; i_reg <= i_next; j_reg <= j_next;
            sw_reg <= sw_next; st_reg <= st_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIZE:  size_reg <= cfg_wdata[5:0];
                    REG_TOL:   tol_reg <= cfg_wdata;
                    REG_LIMIT: lim_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
        zero_reg <= zero_next; conv_reg <= conv_next; acc_reg <= acc_next;
        b_reg <= b_next; d_reg <= d_next;
        if (state_reg == S_OUT) begin
            m_data_reg <= {st_reg, sw_reg,
                (st_reg == ST_ZERO_DIAG) ? 32'd0 : c_rd, 5'(i_reg)};
            m_last_reg <= (i_reg + 1'b1 == n);
        end
    end
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    `JLS_ASSERT_NEVER(a_busy_in, aclk, aresetn, s_tready && m_tvalid && state_reg != S_IDLE,
        "input ready outside idle")
    `JLS_ASSERT_IMPL(a_div_once, aclk, aresetn, div_start |=> div_busy,
        "divider did not start")
    `JLS_ASSERT_NEVER(a_no_write_while_solve, aclk, aresetn,
        (a_we || b_we) && state_reg != S_IDLE, "store written during solve")
endmodule
`default_nettype wire
